// File: sv/clbm_pkg.sv
// shared types, constants and helpers for the contour line pixel marker
package clbm_pkg;

  localparam int unsigned CoordW     = 24;
  localparam int unsigned LevelW     = 49;
  localparam int unsigned SquareW    = 2 * CoordW - 1;
  localparam int unsigned SumW       = 2 * CoordW;
  localparam int unsigned ColourW    = 8;
  localparam int unsigned PixelW     = 3 * ColourW;
  localparam int unsigned LevelCount = 4;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned RegIdxW    = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_X_ORIGIN    = 3'd0,
    REG_X_INCREMENT = 3'd1,
    REG_Y_ORIGIN    = 3'd2,
    REG_Y_INCREMENT = 3'd3,
    REG_LEVEL_ZERO  = 3'd4,
    REG_LEVEL_ONE   = 3'd5,
    REG_LEVEL_TWO   = 3'd6,
    REG_LEVEL_THREE = 3'd7
  } clbm_reg_e;

  localparam logic [CoordW-1:0] XOriginReset    = 24'd0;
  localparam logic [CoordW-1:0] XIncrementReset = 24'd256;
  localparam logic [CoordW-1:0] YOriginReset    = 24'd0;
  localparam logic [CoordW-1:0] YIncrementReset = 24'd256;

  localparam logic [3:0][LevelW-1:0] LevelReset = {
    49'd17179869184, 49'd8589934592, 49'd4294967296, 49'd0
  };

  // configuration write as seen by the front and back
  typedef struct packed {
    logic               we;
    logic [RegIdxW-1:0] idx;
    logic [LevelW-1:0]  data;
  } clbm_cfg_t;

  // one queued pixel: colour plus the four sample coordinates
  typedef struct packed {
    logic [PixelW-1:0] rgb;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x_left;
    logic [CoordW-1:0] y_up;
  } clbm_item_t;

  // exact square of a signed coordinate, always non-negative
  function automatic logic [SquareW-1:0] square_coord(input logic [CoordW-1:0] a);
    logic signed [SumW-1:0] p;
    p = SumW'($signed(a)) * SumW'($signed(a));
    return p[SquareW-1:0];
  endfunction

  function automatic logic in_band(input logic [LevelW-1:0] lo,
                                   input logic [LevelW-1:0] hi,
                                   input logic [LevelW-1:0] z);
    return ($signed(lo) < $signed(z)) && ($signed(z) < $signed(hi));
  endfunction

endpackage

// File: sv/clbm_front.sv
// front end: pixel intake and coordinate tracking
module clbm_front import clbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clbm_cfg_t         cfg_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [PixelW-1:0] rgb_i,
  input  logic              eor_i,
  input  logic              eof_i,
  output logic              push_o,
  output clbm_item_t        item_o,
  input  logic              full_i
);

  logic [CoordW-1:0] x_origin_q, x_inc_q, y_origin_q, y_inc_q;
  logic [CoordW-1:0] col_q, col_d, row_q, row_d;
  logic              take;

  assign ready_o = !full_i;
  assign take    = valid_i && !full_i;
  assign push_o  = take;

  assign item_o.rgb    = rgb_i;
  assign item_o.x      = col_q;
  assign item_o.y      = row_q;
  assign item_o.x_left = col_q - x_inc_q;
  assign item_o.y_up   = row_q - y_inc_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_i.we && cfg_i.idx == REG_X_ORIGIN) begin
      col_d = cfg_i.data[CoordW-1:0];
    end else if (cfg_i.we && cfg_i.idx == REG_Y_ORIGIN) begin
      row_d = cfg_i.data[CoordW-1:0];
    end else if (take) begin
      if (eof_i) begin
        col_d = x_origin_q;
        row_d = y_origin_q;
      end else if (eor_i) begin
        col_d = x_origin_q;
        row_d = row_q + y_inc_q;
      end else begin
        col_d = col_q + x_inc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= XOriginReset;
      x_inc_q    <= XIncrementReset;
      y_origin_q <= YOriginReset;
      y_inc_q    <= YIncrementReset;
      col_q      <= XOriginReset;
      row_q      <= YOriginReset;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_i.we) begin
        unique case (cfg_i.idx)
          REG_X_ORIGIN:    x_origin_q <= cfg_i.data[CoordW-1:0];
          REG_X_INCREMENT: x_inc_q    <= cfg_i.data[CoordW-1:0];
          REG_Y_ORIGIN:    y_origin_q <= cfg_i.data[CoordW-1:0];
          REG_Y_INCREMENT: y_inc_q    <= cfg_i.data[CoordW-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/clbm_fifo.sv
// short queue between front and back
module clbm_fifo import clbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  clbm_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output clbm_item_t item_o
);

  clbm_item_t           mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = count_q == (QueuePtrW+1)'(QueueDepth);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/clbm_back.sv
// back end: squares, band tests and output register
module clbm_back import clbm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clbm_cfg_t         cfg_i,
  input  logic              valid_i,
  input  clbm_item_t        item_i,
  output logic              pop_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [PixelW-1:0] rgb_o,
  output logic              contour_o
);

  logic [LevelW-1:0] level_q [LevelCount];

  // stage 1: squares
  logic               s1_v_q;
  logic [PixelW-1:0]  s1_rgb_q;
  logic [SquareW-1:0] sq_x_q, sq_y_q, sq_xl_q, sq_yu_q;
  // stage 2: sums
  logic               s2_v_q;
  logic [PixelW-1:0]  s2_rgb_q;
  logic [SumW-1:0]    z_q, zx_q, zy_q;
  // stage 3: output
  logic               out_v_q;
  logic [PixelW-1:0]  out_rgb_q;
  logic               out_hit_q;

  logic out_adv, s2_adv, s1_adv, hit;

  assign out_adv = !out_v_q || ready_i;
  assign s2_adv  = !s2_v_q || out_adv;
  assign s1_adv  = !s1_v_q || s2_adv;
  assign pop_o   = valid_i && s1_adv;

  assign valid_o   = out_v_q;
  assign rgb_o     = out_rgb_q;
  assign contour_o = out_hit_q;

  always_comb begin
    logic [LevelW-1:0] z, zx, zy;
    logic              m;
    z   = {1'b0, z_q};
    zx  = {1'b0, zx_q};
    zy  = {1'b0, zy_q};
    hit = 1'b0;
    for (int j = 0; j < LevelCount - 1; j++) begin
      m = in_band(level_q[j], level_q[j+1], z);
      if (in_band(level_q[j], level_q[j+1], zx) != m ||
          in_band(level_q[j], level_q[j+1], zy) != m) begin
        hit = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s1_rgb_q <= item_i.rgb;
      sq_x_q   <= square_coord(item_i.x);
      sq_y_q   <= square_coord(item_i.y);
      sq_xl_q  <= square_coord(item_i.x_left);
      sq_yu_q  <= square_coord(item_i.y_up);
    end
    if (s2_adv) begin
      s2_rgb_q <= s1_rgb_q;
      z_q      <= {1'b0, sq_x_q} + {1'b0, sq_y_q};
      zx_q     <= {1'b0, sq_xl_q} + {1'b0, sq_y_q};
      zy_q     <= {1'b0, sq_x_q} + {1'b0, sq_yu_q};
    end
    if (out_adv) begin
      out_rgb_q <= hit ? '0 : s2_rgb_q;
      out_hit_q <= hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k < LevelCount; k++) begin
        level_q[k] <= LevelReset[k];
      end
    end else begin
      if (s1_adv) begin
        s1_v_q <= valid_i;
      end
      if (s2_adv) begin
        s2_v_q <= s1_v_q;
      end
      if (out_adv) begin
        out_v_q <= s2_v_q;
      end
      for (int k = 0; k < LevelCount; k++) begin
        if (cfg_i.we && cfg_i.idx == RegIdxW'(REG_LEVEL_ZERO + k)) begin
          level_q[k] <= cfg_i.data;
        end
      end
    end
  end

endmodule

// File: sv/contour_line_pixel_marker_top.sv
// top level of the contour line pixel marker
//
//   channel  direction  handshake              contents
//   s_axis   in         tvalid/tready          pixel, row end (tlast), frame end (tuser)
//   m_axis   out        tvalid/tready          pixel, contour flag (tuser)
//   cfg      in         write enable only      register index and data, no read-back
//
// one word per clock sustained when nothing stalls; a word passes from intake through the
// queue write, squares, sums and band test into the output register
// reset empties the queue and pipeline and loads origins, steps of 1/256 and levels 0, 1, 2, 4
// a stalled output fills the three back stages, then the four-entry queue; intake
// drops tready only when the queue is full
module contour_line_pixel_marker_top import clbm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave side
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PixelW-1:0]     s_axis_tdata_i,   // red_in, green_in, blue_in
  input  logic                  s_axis_tlast_i,   // end_of_row
  input  logic                  s_axis_tuser_i,   // end_of_frame
  // master side
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [PixelW-1:0]     m_axis_tdata_o,   // red_out, green_out, blue_out
  output logic                  m_axis_tuser_o,   // on_contour
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [RegIdxW-1:0]    cfg_index_i,
  input  logic [LevelW-1:0]     cfg_data_i
);

  clbm_cfg_t  cfg;
  clbm_item_t push_item, head_item;
  logic       push, full, head_valid, pop;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_index_i;
  assign cfg.data = cfg_data_i;

  // intake and coordinate accumulators
  clbm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .rgb_i   (s_axis_tdata_i),
    .eor_i   (s_axis_tlast_i),
    .eof_i   (s_axis_tuser_i),
    .push_o  (push),
    .item_o  (push_item),
    .full_i  (full)
  );

  // decoupling queue
  clbm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  // arithmetic pipeline and output register
  clbm_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (head_valid),
    .item_i    (head_item),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .rgb_o     (m_axis_tdata_o),
    .contour_o (m_axis_tuser_o)
  );

endmodule

// File: sim/tb_contour_line_pixel_marker_top.sv
// self-checking testbench for the contour line pixel marker top level
module tb_contour_line_pixel_marker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clbm_pkg::*;

  // coordinate and level extremes
  localparam logic [CoordW-1:0] CoordMin = 24'h800000;
  localparam logic [CoordW-1:0] CoordMax = 24'h7FFFFF;
  localparam logic [CoordW-1:0] CoordOne = 24'h010000;
  localparam logic [CoordW-1:0] CoordMinusTwo = 24'hFE0000;
  localparam logic [LevelW-1:0] LevelMin = 49'h1_0000_0000_0000;
  localparam logic [LevelW-1:0] LevelMax = 49'h0_FFFF_FFFF_FFFF;
  // largest possible z, both coordinates at the negative extreme
  localparam logic [LevelW-1:0] LevelTop = 49'h0_8000_0000_0000;

  localparam int unsigned LightIdlePct  = 20;
  localparam int unsigned HeavyIdlePct  = 87;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned SettleCycles  = 10;
  localparam int unsigned MaxReported   = 10;
  localparam int unsigned PhaseItems    = 60;

  typedef enum int {
    RX_HEAVY,  // sender idles lightly, receiver heavily
    TX_HEAVY,  // sender idles heavily, receiver lightly
    NO_IDLE
  } idle_mode_e;

  // one output word as predicted
  typedef struct packed {
    logic [PixelW-1:0] rgb;
    logic              mark;
  } marked_word_t;

  // a full register setting
  typedef struct packed {
    logic [CoordW-1:0]                 x_org;
    logic [CoordW-1:0]                 x_step;
    logic [CoordW-1:0]                 y_org;
    logic [CoordW-1:0]                 y_step;
    logic [LevelCount-1:0][LevelW-1:0] lvl;
  } setup_t;

  // predicts the marked pixels and checks what the block sends out
  class contour_scoreboard;
    logic [CoordW-1:0]                 x_org, x_step, y_org, y_step;
    logic [LevelCount-1:0][LevelW-1:0] lvl;
    logic [CoordW-1:0]                 col, row;
    marked_word_t                      pending_q[$];
    int unsigned                       mismatches, words_in, words_out, marked;

    function new();
      x_org      = '0;
      x_step     = 24'd256;
      y_org      = '0;
      y_step     = 24'd256;
      lvl        = {49'd17179869184, 49'd8589934592, 49'd4294967296, 49'd0};
      col        = x_org;
      row        = y_org;
      mismatches = 0;
      words_in   = 0;
      words_out  = 0;
      marked     = 0;
    endfunction

    function longint square_sum(logic [CoordW-1:0] xr, logic [CoordW-1:0] yr);
      longint xs, ys;
      xs = longint'($signed(xr));
      ys = longint'($signed(yr));
      return xs * xs + ys * ys;
    endfunction

    function bit strictly_between(longint lo, longint hi, longint v);
      return (lo < v) && (v < hi);
    endfunction

    // origin writes also reposition the running coordinate
    function void set_reg(clbm_reg_e idx, logic [LevelW-1:0] val);
      case (idx)
        REG_X_ORIGIN: begin
          x_org = val[CoordW-1:0];
          col   = x_org;
        end
        REG_X_INCREMENT: x_step = val[CoordW-1:0];
        REG_Y_ORIGIN: begin
          y_org = val[CoordW-1:0];
          row   = y_org;
        end
        REG_Y_INCREMENT: y_step = val[CoordW-1:0];
        REG_LEVEL_ZERO:  lvl[0] = val;
        REG_LEVEL_ONE:   lvl[1] = val;
        REG_LEVEL_TWO:   lvl[2] = val;
        REG_LEVEL_THREE: lvl[3] = val;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PixelW-1:0] rgb, logic eor, logic eof);
      logic [CoordW-1:0] x_left, y_up;
      longint            z, z_left, z_up, lo, hi;
      bit                hit, m;
      int                j;
      marked_word_t      w;
      x_left = col - x_step;
      y_up   = row - y_step;
      z      = square_sum(col, row);
      z_left = square_sum(x_left, row);
      z_up   = square_sum(col, y_up);
      hit    = 1'b0;
      for (j = 0; j + 1 < LevelCount; j++) begin
        lo = longint'($signed(lvl[j]));
        hi = longint'($signed(lvl[j+1]));
        m  = strictly_between(lo, hi, z);
        if (strictly_between(lo, hi, z_left) != m || strictly_between(lo, hi, z_up) != m)
          hit = 1'b1;
      end
      w.rgb  = hit ? '0 : rgb;
      w.mark = hit;
      pending_q.push_back(w);
      words_in++;
      if (hit) marked++;
      // frame end wins over row end
      if (eof) begin
        col = x_org;
        row = y_org;
      end else if (eor) begin
        col = x_org;
        row = row + y_step;
      end else begin
        col = col + x_step;
      end
    endfunction

    function void check_word(logic [PixelW-1:0] rgb, logic mark);
      marked_word_t w;
      words_out++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("unexpected word rgb %06h mark %0b with nothing pending", rgb, mark);
        return;
      end
      w = pending_q.pop_front();
      if (w.rgb[7:0] !== rgb[7:0] || w.rgb[15:8] !== rgb[15:8] ||
          w.rgb[23:16] !== rgb[23:16] || w.mark !== mark) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("word %0d: expected r %02h g %02h b %02h mark %0b, got %02h %02h %02h %0b",
                   words_out, w.rgb[7:0], w.rgb[15:8], w.rgb[23:16], w.mark,
                   rgb[7:0], rgb[15:8], rgb[23:16], mark);
      end
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [PixelW-1:0] s_axis_tdata_i;   // red_in, green_in, blue_in
  logic              s_axis_tlast_i;   // end_of_row
  logic              s_axis_tuser_i;   // end_of_frame
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [PixelW-1:0] m_axis_tdata_o;   // red_out, green_out, blue_out
  logic              m_axis_tuser_o;   // on_contour
  logic              cfg_we_i;
  logic [RegIdxW-1:0] cfg_index_i;
  logic [LevelW-1:0] cfg_data_i;

  contour_scoreboard sb = new();

  // idling pattern and output hold-off request, both read by the receiver
  idle_mode_e  idle_mode = RX_HEAVY;
  logic        hold_flip = 1'b0;
  int unsigned reg_writes = 0;
  int unsigned settings   = 0;

  contour_line_pixel_marker_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // generous upper bound on the whole run
  initial begin
    #2_000_000;
    $display("run did not finish in time, %0d words still pending", sb.pending());
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned sender_gap_pct();
    case (idle_mode)
      RX_HEAVY: return LightIdlePct;
      TX_HEAVY: return HeavyIdlePct;
      default:  return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_gap_pct();
    case (idle_mode)
      RX_HEAVY: return HeavyIdlePct;
      TX_HEAVY: return LightIdlePct;
      default:  return 0;
    endcase
  endfunction

  // both handshakes sampled on the pre-edge values, inputs are driven with nonblocking writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        sb.note_pixel(s_axis_tdata_i, s_axis_tlast_i, s_axis_tuser_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        sb.check_word(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // output side: random back-pressure plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_left;
    logic        hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        hold_left = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= receiver_gap_pct());
      end
    end
  end

  // offer one word after a random gap and hold it until taken
  task automatic send_pixel(input logic [PixelW-1:0] rgb, input logic eor, input logic eof);
    while ($urandom_range(99) < sender_gap_pct()) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= rgb;
    s_axis_tlast_i  <= eor;
    s_axis_tuser_i  <= eof;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // stop offering and let every predicted word come out
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // leaves the write enable high, the caller lowers it after the last write
  task automatic write_reg(input clbm_reg_e idx, input logic [LevelW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    sb.set_reg(idx, val);
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic apply_setup(input setup_t s);
    wait_idle();
    write_reg(REG_X_ORIGIN,    LevelW'($signed(s.x_org)));
    write_reg(REG_X_INCREMENT, LevelW'($signed(s.x_step)));
    write_reg(REG_Y_ORIGIN,    LevelW'($signed(s.y_org)));
    write_reg(REG_Y_INCREMENT, LevelW'($signed(s.y_step)));
    write_reg(REG_LEVEL_ZERO,  s.lvl[0]);
    write_reg(REG_LEVEL_ONE,   s.lvl[1]);
    write_reg(REG_LEVEL_TWO,   s.lvl[2]);
    write_reg(REG_LEVEL_THREE, s.lvl[3]);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // signed coordinate of random magnitude below 2^mag_bits
  function automatic logic [CoordW-1:0] rand_coord(input int unsigned mag_bits);
    int v;
    v = int'($urandom_range((1 << mag_bits) - 1));
    if ($urandom_range(1) != 0) v = -v;
    return v[CoordW-1:0];
  endfunction

  // levels are taken from z at random points so that contours actually cross the raster;
  // a quarter of the settings keep them unordered
  function automatic setup_t random_setup(input bit wide);
    setup_t            s;
    longint            lv [LevelCount];
    longint            t;
    logic [LevelW-1:0] raw;
    int                i, j;
    if (wide) begin
      s.x_org  = CoordW'($urandom());
      s.x_step = CoordW'($urandom());
      s.y_org  = CoordW'($urandom());
      s.y_step = CoordW'($urandom());
      raw      = LevelW'({$urandom(), $urandom()});
      lv[0]    = longint'($signed(raw));
      for (i = 1; i < LevelCount; i++)
        lv[i] = sb.square_sum(CoordW'($urandom()), CoordW'($urandom()));
    end else begin
      s.x_org  = rand_coord(18);
      s.x_step = rand_coord(16);
      s.y_org  = rand_coord(18);
      s.y_step = rand_coord(16);
      for (i = 0; i < LevelCount; i++)
        lv[i] = sb.square_sum(rand_coord(18), rand_coord(18));
    end
    if ($urandom_range(3) != 0) begin
      for (i = 0; i < LevelCount - 1; i++)
        for (j = 0; j < LevelCount - 1 - i; j++)
          if (lv[j] > lv[j+1]) begin
            t       = lv[j];
            lv[j]   = lv[j+1];
            lv[j+1] = t;
          end
    end
    for (i = 0; i < LevelCount; i++)
      s.lvl[i] = lv[i][LevelW-1:0];
    return s;
  endfunction

  // mostly whole frames with random colours, some words with random row and frame marks
  task automatic random_phase(input bit wide, input bit hold_off);
    int unsigned sent, cols, rows, r, c;
    apply_setup(random_setup(wide));
    if (hold_off) hold_flip <= ~hold_flip;
    sent = 0;
    while (sent < PhaseItems) begin
      if ($urandom_range(99) < 85) begin
        cols = $urandom_range(10, 1);
        rows = $urandom_range(4, 1);
        for (r = 0; r < rows; r++)
          for (c = 0; c < cols; c++) begin
            send_pixel(PixelW'($urandom()), c == cols - 1,
                       (r == rows - 1) && (c == cols - 1));
            sent++;
          end
      end else begin
        send_pixel(PixelW'($urandom()), 1'($urandom_range(1)), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    setup_t s;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    s_axis_tuser_i  <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= REG_X_ORIGIN;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: origin pixel sits on level zero, colour extremes, row end,
    // row and frame end together (frame end wins)
    send_pixel(24'h000000, 1'b0, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0, 1'b0);
    send_pixel(24'hAA55AA, 1'b1, 1'b0);
    send_pixel(24'h55AA55, 1'b0, 1'b0);
    send_pixel(24'h123456, 1'b1, 1'b1);
    send_pixel(24'hFEDCBA, 1'b0, 1'b0);

    // unit steps from -2.0: z lands exactly on the levels, which belong to no band
    s.x_org  = CoordMinusTwo;
    s.x_step = CoordOne;
    s.y_org  = CoordMinusTwo;
    s.y_step = CoordOne;
    s.lvl    = {49'd17179869184, 49'd8589934592, 49'd4294967296, 49'd0};
    apply_setup(s);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 5; c++)
        send_pixel(PixelW'($urandom()), c == 4, 1'b0);
    send_pixel(PixelW'($urandom()), 1'b0, 1'b0);
    send_pixel(PixelW'($urandom()), 1'b0, 1'b1);

    // extremes: coordinates wrap, largest z equals a level, last band is empty
    s.x_org  = CoordMax;
    s.x_step = CoordMax;
    s.y_org  = CoordMin;
    s.y_step = CoordMin;
    s.lvl    = {49'd0, LevelTop, LevelMax, LevelMin};
    apply_setup(s);
    send_pixel(PixelW'($urandom()), 1'b0, 1'b0);
    send_pixel(PixelW'($urandom()), 1'b1, 1'b0);
    send_pixel(PixelW'($urandom()), 1'b0, 1'b0);
    send_pixel(PixelW'($urandom()), 1'b0, 1'b1);

    // random settings under the three idling patterns
    random_phase(1'b0, 1'b0);
    random_phase(1'b1, 1'b0);
    idle_mode <= TX_HEAVY;
    random_phase(1'b0, 1'b0);
    random_phase(1'b0, 1'b0);
    idle_mode <= NO_IDLE;
    // output held off while words keep coming, the queue fills and intake stalls
    random_phase(1'b0, 1'b1);
    random_phase(1'b1, 1'b0);

    wait_idle();
    repeat (2 * SettleCycles) @(posedge clk_i);
    $display("%0d pixels in, %0d out, %0d on a contour, %0d writes in %0d settings",
             sb.words_in, sb.words_out, sb.marked, reg_writes, settings);
    $display("covered colour extremes, row and frame marks, level ties, coordinate wrap, %s",
             "unordered levels, a long output stall and three idling patterns");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d words never arrived", sb.mismatches, sb.pending());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
